// ===== rtl/c8alu_pkg.sv =====
// ----------------------------------------------------------------------------
// c8alu_pkg
// Shared types and operation codes for the 8-bit CPU ALU with Z/N/H/C flags.
// ----------------------------------------------------------------------------
package c8alu_pkg;

  localparam int unsigned OpW   = 6;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitW  = 3;
  localparam int unsigned FlagW = 4;

  // flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 6'd0,
    OP_ADC    = 6'd1,
    OP_SUB    = 6'd2,
    OP_SBC    = 6'd3,
    OP_AND    = 6'd4,
    OP_XOR    = 6'd5,
    OP_OR     = 6'd6,
    OP_CP     = 6'd7,
    OP_INC8   = 6'd8,
    OP_DEC8   = 6'd9,
    OP_INC16  = 6'd10,
    OP_DEC16  = 6'd11,
    OP_ADD16  = 6'd12,
    OP_SPOFS  = 6'd13,
    OP_RLCA   = 6'd14,
    OP_RRCA   = 6'd15,
    OP_RLA    = 6'd16,
    OP_RRA    = 6'd17,
    OP_DAA    = 6'd18,
    OP_CPL    = 6'd19,
    OP_SCF    = 6'd20,
    OP_CCF    = 6'd21,
    OP_RLC    = 6'd22,
    OP_RRC    = 6'd23,
    OP_RL     = 6'd24,
    OP_RR     = 6'd25,
    OP_SLA    = 6'd26,
    OP_SRA    = 6'd27,
    OP_SWAP   = 6'd28,
    OP_SRL    = 6'd29,
    OP_BIT    = 6'd30,
    OP_RES    = 6'd31,
    OP_SET    = 6'd32
  } alu_op_t;

  localparam logic [ByteW-1:0] DaaLoAdj   = 8'h06;
  localparam logic [ByteW-1:0] DaaHiAdj   = 8'h60;
  localparam logic [ByteW-1:0] DaaHiLimit = 8'h99;
  localparam logic [3:0]       DaaLoLimit = 4'h9;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [WordW-1:0] first_operand;
    logic [WordW-1:0] second_operand;
    logic [BitW-1:0]  bit_index;
    logic [FlagW-1:0] flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [WordW-1:0] result_value;
    logic [FlagW-1:0] flags_out;
  } alu_out_t;

endpackage

// ===== rtl/cpu8_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// cpu8_alu_with_flags
// 8-bit CPU ALU: arithmetic, logic, 16-bit adds, rotates, shifts, DAA and bit
// operations with Z/N/H/C flag generation.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+--------------------------
//   in      | input     | in_valid/in_stall   | c8alu_pkg::alu_in_t
//   out     | output    | out_valid/out_stall | c8alu_pkg::alu_out_t
//
// One beat per cycle sustained while out_stall is low; each input beat passes
// through the input register and then the result register to the result beat.
// Synchronous active-low reset clears both stage valid bits only.
// out_stall holds the result register; the input register keeps filling and
// in_stall rises only once both stages hold a beat.
// ----------------------------------------------------------------------------
module cpu8_alu_with_flags (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  c8alu_pkg::alu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output c8alu_pkg::alu_out_t out_data
);

  logic                 s1_valid_r;
  c8alu_pkg::alu_in_t   s1_data_r;
  logic                 out_valid_r;
  c8alu_pkg::alu_out_t  out_data_r;
  c8alu_pkg::alu_out_t  res_nxt;
  logic                 adv2;
  logic                 adv1;

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] x16;
  logic [15:0] y16;
  logic [3:0]  f;
  logic        zi, ni, hi, ci;
  logic        t;
  logic [8:0]  sum9;
  logic [4:0]  half5;
  logic [8:0]  dif9;
  logic [4:0]  hdif5;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [8:0]  spc9;
  logic [4:0]  sph5;
  logic [7:0]  adj;
  logic        daa_c;
  logic [7:0]  daa_r;
  logic [7:0]  bmask;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic [3:0]  fo;

  assign adv2      = !out_valid_r || !out_stall;
  assign adv1      = !s1_valid_r || adv2;
  assign in_stall  = !adv1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    x16   = s1_data_r.first_operand;
    y16   = s1_data_r.second_operand;
    a     = x16[7:0];
    b     = y16[7:0];
    f     = s1_data_r.flags_in;
    zi    = f[c8alu_pkg::FlagZ];
    ni    = f[c8alu_pkg::FlagN];
    hi    = f[c8alu_pkg::FlagH];
    ci    = f[c8alu_pkg::FlagC];
    t     = ci && (s1_data_r.op == c8alu_pkg::OP_ADC || s1_data_r.op == c8alu_pkg::OP_SBC);
    sum9  = {1'b0, a} + {1'b0, b} + {8'b0, t};
    half5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, t};
    dif9  = {1'b0, a} - {1'b0, b} - {8'b0, t};
    hdif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, t};
    sum17 = {1'b0, x16} + {1'b0, y16};
    sum13 = {1'b0, x16[11:0]} + {1'b0, y16[11:0]};
    spc9  = {1'b0, x16[7:0]} + {1'b0, b};
    sph5  = {1'b0, x16[3:0]} + {1'b0, b[3:0]};
    adj   = 8'h00;
    daa_c = 1'b0;
    if (hi || (!ni && a[3:0] > c8alu_pkg::DaaLoLimit)) begin
      adj = adj | c8alu_pkg::DaaLoAdj;
    end
    if (ci || (!ni && a > c8alu_pkg::DaaHiLimit)) begin
      adj   = adj | c8alu_pkg::DaaHiAdj;
      daa_c = 1'b1;
    end
    daa_r = ni ? (a - adj) : (a + adj);
    bmask = 8'b1 << s1_data_r.bit_index;

    r8  = 8'h00;
    r16 = 16'h0000;
    fo  = f;
    case (s1_data_r.op)
      c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC: begin
        r8 = sum9[7:0];
        fo = {r8 == 8'h00, 1'b0, half5[4], sum9[8]};
      end
      c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC: begin
        r8 = dif9[7:0];
        fo = {r8 == 8'h00, 1'b1, hdif5[4], dif9[8]};
      end
      c8alu_pkg::OP_CP: begin
        r8 = a;
        fo = {dif9[7:0] == 8'h00, 1'b1, hdif5[4], dif9[8]};
      end
      c8alu_pkg::OP_AND: begin
        r8 = a & b;
        fo = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      c8alu_pkg::OP_XOR: begin
        r8 = a ^ b;
        fo = {r8 == 8'h00, 3'b000};
      end
      c8alu_pkg::OP_OR: begin
        r8 = a | b;
        fo = {r8 == 8'h00, 3'b000};
      end
      c8alu_pkg::OP_INC8: begin
        r8 = a + 8'd1;
        fo = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, ci};
      end
      c8alu_pkg::OP_DEC8: begin
        r8 = a - 8'd1;
        fo = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, ci};
      end
      c8alu_pkg::OP_INC16: r16 = x16 + 16'd1;
      c8alu_pkg::OP_DEC16: r16 = x16 - 16'd1;
      c8alu_pkg::OP_ADD16: begin
        r16 = sum17[15:0];
        fo  = {zi, 1'b0, sum13[12], sum17[16]};
      end
      c8alu_pkg::OP_SPOFS: begin
        r16 = x16 + {{8{b[7]}}, b};
        fo  = {2'b00, sph5[4], spc9[8]};
      end
      c8alu_pkg::OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        fo = {3'b000, a[7]};
      end
      c8alu_pkg::OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        fo = {3'b000, a[0]};
      end
      c8alu_pkg::OP_RLA: begin
        r8 = {a[6:0], ci};
        fo = {3'b000, a[7]};
      end
      c8alu_pkg::OP_RRA: begin
        r8 = {ci, a[7:1]};
        fo = {3'b000, a[0]};
      end
      c8alu_pkg::OP_DAA: begin
        r8 = daa_r;
        fo = {r8 == 8'h00, ni, 1'b0, daa_c};
      end
      c8alu_pkg::OP_CPL: begin
        r8 = ~a;
        fo = {zi, 1'b1, 1'b1, ci};
      end
      c8alu_pkg::OP_SCF: begin
        r8 = a;
        fo = {zi, 1'b0, 1'b0, 1'b1};
      end
      c8alu_pkg::OP_CCF: begin
        r8 = a;
        fo = {zi, 1'b0, 1'b0, !ci};
      end
      c8alu_pkg::OP_RLC: begin
        r8 = {a[6:0], a[7]};
        fo = {r8 == 8'h00, 2'b00, a[7]};
      end
      c8alu_pkg::OP_RRC: begin
        r8 = {a[0], a[7:1]};
        fo = {r8 == 8'h00, 2'b00, a[0]};
      end
      c8alu_pkg::OP_RL: begin
        r8 = {a[6:0], ci};
        fo = {r8 == 8'h00, 2'b00, a[7]};
      end
      c8alu_pkg::OP_RR: begin
        r8 = {ci, a[7:1]};
        fo = {r8 == 8'h00, 2'b00, a[0]};
      end
      c8alu_pkg::OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        fo = {r8 == 8'h00, 2'b00, a[7]};
      end
      c8alu_pkg::OP_SRA: begin
        r8 = {a[7], a[7:1]};
        fo = {r8 == 8'h00, 2'b00, a[0]};
      end
      c8alu_pkg::OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        fo = {r8 == 8'h00, 3'b000};
      end
      c8alu_pkg::OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        fo = {r8 == 8'h00, 2'b00, a[0]};
      end
      c8alu_pkg::OP_BIT: begin
        r8 = a;
        fo = {(a & bmask) == 8'h00, 1'b0, 1'b1, ci};
      end
      c8alu_pkg::OP_RES: r8 = a & ~bmask;
      c8alu_pkg::OP_SET: r8 = a | bmask;
      default: begin
        r8  = 8'h00;
        r16 = 16'h0000;
        fo  = f;
      end
    endcase
    res_nxt.result_value = r16 | {8'h00, r8};
    res_nxt.flags_out    = fo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_valid;
      end
      if (adv2) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_data_r <= in_data;
    end
    if (adv2 && s1_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv2) |=> out_valid_r)
    else $error("beat lost between stages");

  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv2) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input stage dropped a blocked beat");

endmodule
